// ----- hdl/fpe_pkg.sv -----
`timescale 1ns / 1ps
// Package for the format-preserving Feistel cipher core.
// Holds the hash constants, config register codes, shared types and the
// domain geometry function. No dependencies.
package fpe_pkg;

  localparam logic [31:0] HASH_MUL_A = 32'd747796405;
  localparam logic [31:0] HASH_ADD_A = 32'd2891336453;
  localparam logic [31:0] HASH_MUL_B = 32'd277803737;
  localparam logic [4:0]  HASH_TOP_SHIFT = 5'd28;
  localparam logic [4:0]  HASH_SHIFT_BIAS = 5'd4;
  localparam logic [4:0]  HASH_FOLD_SHIFT = 5'd22;

  localparam logic [1:0] CFG_KEY        = 2'd0;
  localparam logic [1:0] CFG_NUM_ITEMS  = 2'd1;
  localparam logic [1:0] CFG_NUM_ROUNDS = 2'd2;

  localparam logic [31:0] KEY_RESET        = 32'd0;
  localparam logic [31:0] NUM_ITEMS_RESET  = 32'd256;
  localparam logic [4:0]  NUM_ROUNDS_RESET = 5'd4;

  // Split of the domain into a left half of lb bits and a right half of rb bits.
  typedef struct packed {
    logic [4:0]  lb;
    logic [4:0]  rb;
    logic [15:0] lmask;
    logic [15:0] rmask;
  } fpe_geom_t;

  // One transaction as it travels down the chain of round cells.
  typedef struct packed {
    logic        valid;
    logic        cmd;
    logic [31:0] word;
  } fpe_item_t;

  localparam logic FPE_CMD_ENCRYPT = 1'b0;
  localparam logic FPE_CMD_DECRYPT = 1'b1;

  function automatic fpe_geom_t fpe_geometry(input logic [31:0] num_items);
    logic [31:0] span;
    logic [5:0]  nb;
    logic [16:0] lm;
    logic [16:0] rm;
    fpe_geom_t   g;
    span = num_items - 32'd1;
    nb = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (span[i]) begin
        nb = 6'(i + 1);
      end
    end
    g.lb = nb[5:1];
    g.rb = 5'(nb - {1'b0, nb[5:1]});
    lm = (17'd1 << g.lb) - 17'd1;
    rm = (17'd1 << g.rb) - 17'd1;
    g.lmask = lm[15:0];
    g.rmask = rm[15:0];
    return g;
  endfunction

endpackage

// ----- hdl/fpe_round_cell.sv -----
`timescale 1ns / 1ps
// One Feistel round as a five-stage pipeline cell of the cipher chain.
// Depends on fpe_pkg for the hash constants, item and geometry types.
module fpe_round_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [31:0]       key,
  input  logic [4:0]        num_rounds,
  input  fpe_pkg::fpe_geom_t geom,
  input  fpe_pkg::fpe_item_t in_item,
  output fpe_pkg::fpe_item_t out_item
);
  import fpe_pkg::*;

  fpe_item_t   item_x_r, item_s_r, item_t_r, item_m_r, item_w_r;
  logic [31:0] x_r, s_r, t_r, m_r;
  logic [31:0] x_nxt, s_nxt, t_nxt, m_nxt;
  logic [31:0] word_nxt;
  logic [4:0]  t_shift;
  logic [31:0] hash;
  logic [31:0] enc_hi, enc_lo, enc_new;
  logic [31:0] dec_hi, dec_lo, dec_new;
  logic        active;

  // Hash input: encrypt hashes the upper part, decrypt the left half.
  always_comb begin
    if (in_item.cmd == FPE_CMD_ENCRYPT) begin
      x_nxt = (in_item.word >> geom.rb) ^ key;
    end else begin
      x_nxt = (in_item.word & {16'd0, geom.lmask}) ^ key;
    end
  end

  assign s_nxt   = x_r * HASH_MUL_A + HASH_ADD_A;
  assign t_shift = {1'b0, s_r[31:28]} + HASH_SHIFT_BIAS;
  assign t_nxt   = (s_r >> t_shift) ^ s_r;
  assign m_nxt   = t_r * HASH_MUL_B;
  assign hash    = (m_r >> HASH_FOLD_SHIFT) ^ m_r;

  // Rounds past the configured count pass the word through untouched.
  assign active = 32'(IDX) < {27'd0, num_rounds};

  always_comb begin
    enc_hi  = item_m_r.word >> geom.rb;
    enc_lo  = item_m_r.word & {16'd0, geom.rmask};
    enc_new = ((((enc_lo ^ hash) & {16'd0, geom.rmask})) << geom.lb) | enc_hi;
    dec_hi  = item_m_r.word >> geom.lb;
    dec_lo  = item_m_r.word & {16'd0, geom.lmask};
    dec_new = (dec_lo << geom.rb) | ((dec_hi ^ hash) & {16'd0, geom.rmask});
    if (!active) begin
      word_nxt = item_m_r.word;
    end else if (item_m_r.cmd == FPE_CMD_ENCRYPT) begin
      word_nxt = enc_new;
    end else begin
      word_nxt = dec_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_x_r.valid <= 1'b0;
      item_s_r.valid <= 1'b0;
      item_t_r.valid <= 1'b0;
      item_m_r.valid <= 1'b0;
      item_w_r.valid <= 1'b0;
    end else if (advance) begin
      item_x_r.valid <= in_item.valid;
      item_s_r.valid <= item_x_r.valid;
      item_t_r.valid <= item_s_r.valid;
      item_m_r.valid <= item_t_r.valid;
      item_w_r.valid <= item_m_r.valid;
    end
    if (advance) begin
      item_x_r.cmd  <= in_item.cmd;
      item_x_r.word <= in_item.word;
      x_r           <= x_nxt;
      item_s_r.cmd  <= item_x_r.cmd;
      item_s_r.word <= item_x_r.word;
      s_r           <= s_nxt;
      item_t_r.cmd  <= item_s_r.cmd;
      item_t_r.word <= item_s_r.word;
      t_r           <= t_nxt;
      item_m_r.cmd  <= item_t_r.cmd;
      item_m_r.word <= item_t_r.word;
      m_r           <= m_nxt;
      item_w_r.cmd  <= item_m_r.cmd;
      item_w_r.word <= word_nxt;
    end
  end

  assign out_item = item_w_r;

endmodule

// ----- hdl/fpe_out_buf.sv -----
`timescale 1ns / 1ps
// Output register with a one-entry skid stage for the cipher core.
// Depends on fpe_pkg for the item type.
module fpe_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  fpe_pkg::fpe_item_t in_item,
  output logic               advance,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_result
);
  import fpe_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic [31:0] skid_data_r, skid_data_nxt;
  logic        push;

  // The chain only stalls once the skid entry is taken.
  assign advance = !skid_valid_r;
  assign push    = in_item.valid && advance;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = in_item.word;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = in_item.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_data_r;

endmodule

// ----- hdl/feistel_fpe_cipher_core.sv -----
`timescale 1ns / 1ps
// Format-preserving Feistel cipher core: config registers, a chain of
// MAX_ROUNDS round cells (fpe_round_cell) and an output buffer (fpe_out_buf).
// Each round cell is five pipeline stages; a new transaction is taken every
// cycle unless the skid entry is full or a config write is pending.
// Reset is synchronous, active low: it empties the pipeline and restores the
// config registers to key 0, num_items 256, num_rounds 4.
module feistel_fpe_cipher_core #(
  parameter int unsigned MAX_ROUNDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fpe_pkg::*;

  logic [31:0] key_r;
  logic [4:0]  num_rounds_r;
  fpe_geom_t   geom_r;
  logic        advance;
  fpe_item_t   chain [MAX_ROUNDS+1];

  assign cfg_ready = 1'b1;
  // Input holds off during a config write so the new geometry settles first.
  assign in_ready = advance && !cfg_valid;

  // The domain split is taken straight from the written size, so a transaction
  // in the very next cycle already sees the new geometry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r        <= KEY_RESET;
      num_rounds_r <= NUM_ROUNDS_RESET;
      geom_r       <= fpe_geometry(NUM_ITEMS_RESET);
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_KEY:        key_r        <= cfg_data;
          CFG_NUM_ITEMS:  geom_r       <= fpe_geometry(cfg_data);
          CFG_NUM_ROUNDS: num_rounds_r <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  assign chain[0] = '{valid: in_valid && in_ready, cmd: in_cmd, word: in_data};

  for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_round
    fpe_round_cell #(
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .advance    (advance),
      .key        (key_r),
      .num_rounds (num_rounds_r),
      .geom       (geom_r),
      .in_item    (chain[i]),
      .out_item   (chain[i+1])
    );
  end

  fpe_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (chain[MAX_ROUNDS]),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

endmodule

// ----- test/tb_feistel_fpe_cipher_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for feistel_fpe_cipher_core: directed and random transactions
// with a cipher predictor in a small scoreboard class. Depends on fpe_pkg and the core RTL.
module tb_feistel_fpe_cipher_core;
  import fpe_pkg::*;

  localparam int unsigned MAX_ROUNDS = 16;
  localparam int unsigned LATENCY = 5 * MAX_ROUNDS + 1;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;

  localparam logic [31:0] MIX_MUL_A = 32'd747796405;
  localparam logic [31:0] MIX_ADD_A = 32'd2891336453;
  localparam logic [31:0] MIX_MUL_B = 32'd277803737;

  class cipher_scoreboard;
    logic [31:0] key_q;
    logic [31:0] num_items_q;
    logic [4:0]  rounds_q;
    logic [31:0] expected_words[$];
    int          checked;

    function new();
      key_q = 32'd0;
      num_items_q = 32'd256;
      rounds_q = 5'd4;
      checked = 0;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [31:0] val);
      case (idx)
        CFG_KEY:        key_q = val;
        CFG_NUM_ITEMS:  num_items_q = val;
        CFG_NUM_ROUNDS: rounds_q = val[4:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] pcg_mix(input logic [31:0] x);
      logic [31:0] s;
      logic [31:0] w;
      s = x * MIX_MUL_A + MIX_ADD_A;
      w = ((s >> ({1'b0, s[31:28]} + 5'd4)) ^ s) * MIX_MUL_B;
      return (w >> 22) ^ w;
    endfunction

    function logic [31:0] cipher_word(input logic cmd, input logic [31:0] data);
      logic [31:0] span;
      logic [31:0] lmask;
      logic [31:0] rmask;
      logic [31:0] w;
      logic [31:0] hi;
      logic [31:0] lo;
      int nb;
      int lb;
      int rb;
      int rounds;
      span = num_items_q - 32'd1;
      nb = 0;
      for (int i = 0; i < 32; i++) begin
        if (span[i]) begin
          nb = i + 1;
        end
      end
      lb = nb / 2;
      rb = nb - lb;
      lmask = (32'd1 << lb) - 32'd1;
      rmask = (32'd1 << rb) - 32'd1;
      rounds = (rounds_q > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds_q);
      w = data;
      for (int r = 0; r < rounds; r++) begin
        if (cmd == FPE_CMD_ENCRYPT) begin
          // Bits above the right half are kept whole as the left half.
          hi = w >> rb;
          lo = w & rmask;
          w = (((lo ^ pcg_mix(hi ^ key_q)) & rmask) << lb) | hi;
        end else begin
          hi = w >> lb;
          lo = w & lmask;
          w = (lo << rb) | ((hi ^ pcg_mix(lo ^ key_q)) & rmask);
        end
      end
      return w;
    endfunction

    function void note_input(input logic cmd, input logic [31:0] data);
      expected_words.push_back(cipher_word(cmd, data));
    endfunction

    // Returns 0 on a match, 1 on a wrong value, 2 when nothing was expected.
    function int check_result(input logic [31:0] got, output logic [31:0] want);
      want = 32'd0;
      if (expected_words.size() == 0) begin
        return 2;
      end
      want = expected_words.pop_front();
      checked++;
      return (got === want) ? 0 : 1;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [31:0] in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  cipher_scoreboard sb;
  int mismatches = 0;
  int items_sent = 0;
  int settings_used = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  feistel_fpe_cipher_core #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result(out_result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 20) begin
      $display("tb: mismatch at %0t: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Receiver side: stalls come in bursts of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (out_stall_pct != 0 && $urandom_range(99, 0) < out_stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(15, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    int status;
    logic [31:0] want;
    if (rst_n && out_valid && out_ready) begin
      status = sb.check_result(out_result, want);
      if (status == 2) begin
        report_mismatch($sformatf("result %h with no transaction outstanding", out_result));
      end else if (status == 1) begin
        report_mismatch($sformatf("result %h, expected %h", out_result, want));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: no progress for %0d cycles", STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic cmd, input logic [31:0] data);
    if (in_idle_pct != 0 && $urandom_range(99, 0) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(cmd, data);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Each write drops cfg_valid again before the task returns.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_cipher(input logic [31:0] k, input logic [31:0] n, input logic [31:0] r);
    wait_drained();
    write_reg(CFG_KEY, k);
    write_reg(CFG_NUM_ITEMS, n);
    write_reg(CFG_NUM_ROUNDS, r);
    settings_used++;
  endtask

  function automatic logic [31:0] pick_in_domain();
    if (sb.num_items_q == 32'd0) begin
      return $urandom;
    end
    return $urandom_range(sb.num_items_q - 32'd1, 0);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3, 0))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  // Mostly round trips through the cipher on in-domain values, the rest single in-domain or raw words.
  task automatic run_random(input int count);
    int sent;
    int sel;
    logic [31:0] x;
    sent = 0;
    while (sent < count) begin
      sel = $urandom_range(99, 0);
      x = pick_in_domain();
      if (sel < 55) begin
        send_item(FPE_CMD_ENCRYPT, x);
        send_item(FPE_CMD_DECRYPT, sb.cipher_word(FPE_CMD_ENCRYPT, x));
        sent += 2;
      end else if (sel < 75) begin
        send_item(FPE_CMD_DECRYPT, x);
        send_item(FPE_CMD_ENCRYPT, sb.cipher_word(FPE_CMD_DECRYPT, x));
        sent += 2;
      end else if (sel < 85) begin
        send_item(logic'($urandom_range(1, 0)), x);
        sent += 1;
      end else begin
        send_item(logic'($urandom_range(1, 0)), $urandom);
        sent += 1;
      end
    end
  endtask

  task automatic random_setting();
    logic [31:0] k;
    logic [31:0] n;
    logic [31:0] r;
    case ($urandom_range(7, 0))
      0: n = 32'd1 << $urandom_range(31, 0);
      1: n = (32'd1 << $urandom_range(31, 0)) + 32'd1;
      2: n = $urandom;
      3: n = 32'd0;
      4: n = $urandom_range(2, 1);
      5: n = 32'hFFFF_FFFF;
      default: n = $urandom_range(1000, 3);
    endcase
    case ($urandom_range(5, 0))
      0: r = 32'd0;
      1: r = MAX_ROUNDS;
      2: r = $urandom_range(31, MAX_ROUNDS + 1);
      default: r = $urandom_range(MAX_ROUNDS, 1);
    endcase
    case ($urandom_range(3, 0))
      0: k = 32'd0;
      1: k = 32'hFFFF_FFFF;
      default: k = $urandom;
    endcase
    set_cipher(k, n, r);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = FPE_CMD_ENCRYPT;
    in_data = 32'd0;
    cfg_valid = 1'b0;
    cfg_index = CFG_KEY;
    cfg_data = 32'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: 256 values, four rounds, zero key; words in and out of the domain.
    send_item(FPE_CMD_ENCRYPT, 32'd0);
    send_item(FPE_CMD_DECRYPT, 32'd0);
    send_item(FPE_CMD_ENCRYPT, 32'd255);
    send_item(FPE_CMD_DECRYPT, 32'd255);
    send_item(FPE_CMD_ENCRYPT, 32'd256);
    send_item(FPE_CMD_DECRYPT, 32'hFFFF_FFFF);
    send_item(FPE_CMD_ENCRYPT, 32'hFFFF_FFFF);
    settings_used++;

    // A size of zero wraps to the full 32-bit domain.
    set_cipher(32'hFFFF_FFFF, 32'd0, MAX_ROUNDS);
    send_item(FPE_CMD_ENCRYPT, 32'hFFFF_FFFF);
    send_item(FPE_CMD_DECRYPT, 32'hFFFF_FFFF);
    send_item(FPE_CMD_ENCRYPT, 32'h5A5A_A5A5);

    // A size of one leaves both halves empty.
    set_cipher(32'h1234_5678, 32'd1, 32'd3);
    send_item(FPE_CMD_ENCRYPT, 32'd0);
    send_item(FPE_CMD_ENCRYPT, 32'hDEAD_BEEF);
    send_item(FPE_CMD_DECRYPT, 32'd5);

    // No rounds at all: data passes through.
    set_cipher(32'hA5A5_A5A5, 32'd1000, 32'd0);
    send_item(FPE_CMD_ENCRYPT, 32'd999);
    send_item(FPE_CMD_DECRYPT, 32'hFFFF_FFFF);

    // Round counts above the pipeline depth saturate, and high write bits are dropped.
    set_cipher(32'h0F0F_0F0F, 32'hFFFF_FFFF, 32'd31);
    send_item(FPE_CMD_ENCRYPT, 32'hFFFF_FFFE);
    send_item(FPE_CMD_DECRYPT, 32'h8000_0001);
    wait_drained();
    write_reg(CFG_NUM_ROUNDS, 32'hFFFF_FFE0 | MAX_ROUNDS);
    write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
    send_item(FPE_CMD_ENCRYPT, 32'h0000_FFFF);
    send_item(FPE_CMD_DECRYPT, 32'hFFFF_0000);

    for (int phase = 0; phase < 10; phase++) begin
      random_setting();
      in_idle_pct = (phase == 9) ? 0 : pick_pct();
      out_stall_pct = (phase == 9) ? 0 : pick_pct();
      run_random(143);
    end

    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.pending() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));
    end
    $display("tb: %0d transactions sent, %0d results checked over %0d cipher settings",
             items_sent, sb.checked, settings_used);
    $display("tb: %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/fpe_pkg.sv
hdl/fpe_round_cell.sv
hdl/fpe_out_buf.sv
hdl/feistel_fpe_cipher_core.sv
test/tb_feistel_fpe_cipher_core.sv
